// File: sv/x86d_pkg.sv
`default_nettype none

package x86d_pkg;

    // record forms
    localparam logic [4:0] FORM_UNKNOWN      = 5'd0;
    localparam logic [4:0] FORM_ADD_RR       = 5'd1;
    localparam logic [4:0] FORM_OR_RR8       = 5'd2;
    localparam logic [4:0] FORM_SUB_RR       = 5'd3;
    localparam logic [4:0] FORM_JNZ          = 5'd4;
    localparam logic [4:0] FORM_CMP_MEM_IMM  = 5'd5;
    localparam logic [4:0] FORM_SUB_IMM      = 5'd6;
    localparam logic [4:0] FORM_ADD_IMM      = 5'd7;
    localparam logic [4:0] FORM_MOV_RR       = 5'd8;
    localparam logic [4:0] FORM_MOV_DIRECT   = 5'd9;
    localparam logic [4:0] FORM_MOV_BASE     = 5'd10;
    localparam logic [4:0] FORM_MOV_BASE_D8  = 5'd11;
    localparam logic [4:0] FORM_MOV_BASE_D16 = 5'd12;
    localparam logic [4:0] FORM_MOV_AX_MEM   = 5'd13;
    localparam logic [4:0] FORM_MOV_MEM_AL   = 5'd14;
    localparam logic [4:0] FORM_MOV_IMM      = 5'd15;
    localparam logic [4:0] FORM_SHL1         = 5'd16;

    // opcodes
    localparam logic [7:0] OP_ADD_RM16     = 8'h01;
    localparam logic [7:0] OP_OR_R8        = 8'h0A;
    localparam logic [7:0] OP_SUB_RM16     = 8'h29;
    localparam logic [7:0] OP_JNZ          = 8'h75;
    localparam logic [7:0] OP_GRP1_IMM8    = 8'h80;
    localparam logic [7:0] OP_GRP1_IMM16   = 8'h81;
    localparam logic [7:0] OP_MOV_RM16     = 8'h89;
    localparam logic [7:0] OP_MOV_R16      = 8'h8B;
    localparam logic [7:0] OP_MOV_AX_MOFFS = 8'hA1;
    localparam logic [7:0] OP_MOV_MOFFS_AL = 8'hA2;
    localparam logic [7:0] OP_SHL_GRP      = 8'hD0;
    localparam logic [7:0] OP_MOV_IMM_BASE = 8'hB8;

    localparam logic [7:0] CMP_MODRM     = 8'h3E;
    localparam logic [4:0] SHL_MODRM_TOP = 5'h1C;
    localparam logic [2:0] EXT_ADD       = 3'd0;
    localparam logic [2:0] EXT_SUB       = 3'd5;
    localparam logic [2:0] RM_DIRECT     = 3'd6;
    localparam logic [1:0] MOD_NO_DISP   = 2'd0;
    localparam logic [1:0] MOD_DISP8     = 2'd1;
    localparam logic [1:0] MOD_DISP16    = 2'd2;
    localparam logic [1:0] MOD_REG       = 2'd3;

    localparam logic [15:0] LOAD_ADDRESS_RESET = 16'h0100;

    typedef struct packed {
        logic [4:0]  form;
        logic [2:0]  dest_reg;
        logic [2:0]  src_reg;
        logic [15:0] word_value;
        logic [7:0]  byte_value;
        logic [2:0]  length;
        logic [15:0] instr_address;
        logic        is_last;
    } t_rec;

    // up to two records written to the queue per beat, r1 only with r0
    typedef struct packed {
        logic v0;
        logic v1;
        t_rec r0;
        t_rec r1;
    } t_push;

    function automatic logic opens(input logic [7:0] op);
        case (op)
            OP_ADD_RM16, OP_OR_R8, OP_SUB_RM16, OP_JNZ, OP_GRP1_IMM8,
            OP_GRP1_IMM16, OP_MOV_RM16, OP_MOV_R16, OP_MOV_AX_MOFFS,
            OP_MOV_MOFFS_AL, OP_SHL_GRP: return 1'b1;
            default: return op[7:3] == OP_MOV_IMM_BASE[7:3];
        endcase
    endfunction

    // total length from opcode and second byte; zero on mismatch
    function automatic logic [2:0] form_len(input logic [7:0] op, input logic [7:0] m);
        logic [1:0] md;
        logic [2:0] rg;
        logic [2:0] rm;
        md = m[7:6];
        rg = m[5:3];
        rm = m[2:0];
        case (op)
            OP_ADD_RM16, OP_OR_R8, OP_SUB_RM16, OP_MOV_RM16:
                return (md == MOD_REG) ? 3'd2 : 3'd0;
            OP_JNZ: return 3'd2;
            OP_GRP1_IMM8: return (m == CMP_MODRM) ? 3'd5 : 3'd0;
            OP_GRP1_IMM16:
                return (md == MOD_REG && (rg == EXT_SUB || rg == EXT_ADD)) ? 3'd4 : 3'd0;
            OP_MOV_R16: begin
                case (md)
                    MOD_NO_DISP: return (rm == RM_DIRECT) ? 3'd4 : 3'd2;
                    MOD_DISP8:   return 3'd3;
                    MOD_DISP16:  return 3'd4;
                    default:     return 3'd0;
                endcase
            end
            OP_MOV_AX_MOFFS, OP_MOV_MOFFS_AL: return 3'd3;
            OP_SHL_GRP: return (m[7:3] == SHL_MODRM_TOP) ? 3'd2 : 3'd0;
            default: return (op[7:3] == OP_MOV_IMM_BASE[7:3]) ? 3'd3 : 3'd0;
        endcase
    endfunction

    function automatic t_rec unknown_rec(input logic [7:0] b, input logic [2:0] len,
                                         input logic [15:0] addr);
        t_rec r;
        r               = '0;
        r.form          = FORM_UNKNOWN;
        r.byte_value    = b;
        r.length        = len;
        r.instr_address = addr;
        return r;
    endfunction

    function automatic t_rec decode_rec(input logic [7:0] b0, input logic [7:0] b1,
                                        input logic [7:0] b2, input logic [7:0] b3,
                                        input logic [7:0] b4, input logic [2:0] len,
                                        input logic [15:0] base);
        t_rec        r;
        logic [2:0]  rg;
        logic [2:0]  rm;
        logic [1:0]  md;
        logic [15:0] w23;
        logic [15:0] w12;
        rg  = b1[5:3];
        rm  = b1[2:0];
        md  = b1[7:6];
        w23 = {b3, b2};
        w12 = {b2, b1};
        r               = '0;
        r.length        = len;
        r.instr_address = base;
        case (b0)
            OP_ADD_RM16: begin
                r.form = FORM_ADD_RR; r.dest_reg = rm; r.src_reg = rg;
            end
            OP_OR_R8: begin
                r.form = FORM_OR_RR8; r.dest_reg = rg; r.src_reg = rm;
            end
            OP_SUB_RM16: begin
                r.form = FORM_SUB_RR; r.dest_reg = rm; r.src_reg = rg;
            end
            OP_JNZ: begin
                r.form       = FORM_JNZ;
                r.word_value = base + 16'd2 + {{8{b1[7]}}, b1};
            end
            OP_GRP1_IMM8: begin
                r.form = FORM_CMP_MEM_IMM; r.word_value = w23; r.byte_value = b4;
            end
            OP_GRP1_IMM16: begin
                r.form       = (rg == EXT_SUB) ? FORM_SUB_IMM : FORM_ADD_IMM;
                r.dest_reg   = rm;
                r.word_value = w23;
            end
            OP_MOV_RM16: begin
                r.form = FORM_MOV_RR; r.dest_reg = rm; r.src_reg = rg;
            end
            OP_MOV_R16: begin
                r.dest_reg = rg;
                if (md == MOD_NO_DISP && rm == RM_DIRECT) begin
                    r.form = FORM_MOV_DIRECT; r.word_value = w23;
                end else if (md == MOD_NO_DISP) begin
                    r.form = FORM_MOV_BASE; r.src_reg = rm;
                end else if (md == MOD_DISP8) begin
                    r.form = FORM_MOV_BASE_D8; r.src_reg = rm; r.byte_value = b2;
                end else begin
                    r.form = FORM_MOV_BASE_D16; r.src_reg = rm; r.word_value = w23;
                end
            end
            OP_MOV_AX_MOFFS: begin
                r.form = FORM_MOV_AX_MEM; r.word_value = w12;
            end
            OP_MOV_MOFFS_AL: begin
                r.form = FORM_MOV_MEM_AL; r.word_value = w12;
            end
            OP_SHL_GRP: begin
                r.form = FORM_SHL1; r.dest_reg = rm;
            end
            default: begin
                r.form = FORM_MOV_IMM; r.dest_reg = b0[2:0]; r.word_value = w12;
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/x86d_if.sv
`default_nettype none

interface x86d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       end_of_stream;

    modport source (output valid, output code_byte, output end_of_stream, input ready);
    modport sink   (input valid, input code_byte, input end_of_stream, output ready);
endinterface

interface x86d_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  form;
    logic [2:0]  dest_reg;
    logic [2:0]  src_reg;
    logic [15:0] word_value;
    logic [7:0]  byte_value;
    logic [2:0]  length;
    logic [15:0] instr_address;
    logic        is_last;

    modport source (output valid, output form, output dest_reg, output src_reg,
                    output word_value, output byte_value, output length,
                    output instr_address, output is_last, input ready);
    modport sink   (input valid, input form, input dest_reg, input src_reg,
                    input word_value, input byte_value, input length,
                    input instr_address, input is_last, output ready);
endinterface

`default_nettype wire

// File: sv/x86d_front.sv
`default_nettype none

module x86d_front import x86d_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    x86d_in_if.sink          i_in,
    input  wire logic [15:0] i_load_address,
    input  wire logic        i_space_ok,
    output t_push            o_push
);

    logic [7:0]  r_pend [4];
    logic [7:0]  n_pend [4];
    logic [2:0]  r_cnt, n_cnt;
    logic [15:0] r_off, n_off;
    logic [15:0] r_start, n_start;

    logic        accept;
    logic [7:0]  b;
    logic [7:0]  m;
    logic [2:0]  need;
    logic [7:0]  bb [5];
    logic [15:0] addr_off;
    logic [15:0] addr_start;
    logic        e1_v, e2_v, e3_v;
    t_rec        e1, e2, e3;

    assign i_in.ready = i_space_ok;
    assign accept     = i_in.valid && i_space_ok;
    assign b          = i_in.code_byte;
    assign addr_off   = i_load_address + r_off;
    assign addr_start = i_load_address + r_start;
    assign m          = (r_cnt >= 3'd2) ? r_pend[1] : b;
    assign need       = form_len(r_pend[0], m);

    // assembled instruction bytes, held ones first, then this beat, then zero
    always_comb begin
        bb[0] = r_pend[0];
        for (int i = 1; i < 4; i++) begin
            if (3'(i) < r_cnt)       bb[i] = r_pend[i];
            else if (3'(i) == r_cnt) bb[i] = b;
            else                     bb[i] = 8'h00;
        end
        bb[4] = (r_cnt == 3'd4) ? b : 8'h00;
    end

    always_comb begin
        n_pend  = r_pend;
        n_cnt   = r_cnt;
        n_start = r_start;
        n_off   = i_in.end_of_stream ? 16'd0 : r_off + 16'd1;
        e1_v    = 1'b0;
        e2_v    = 1'b0;
        e3_v    = 1'b0;
        e1      = unknown_rec(b, 3'd1, addr_off);
        e2      = unknown_rec(b, 3'd1, addr_off);
        e3      = unknown_rec(b, 3'd1, addr_off);

        if (r_cnt == 3'd0) begin
            if (!opens(b)) begin
                e1_v = 1'b1;
            end else begin
                n_pend[0] = b;
                n_cnt     = 3'd1;
                n_start   = r_off;
            end
        end else if (need == 3'd0) begin
            // held first byte fails, this byte starts over as an opcode
            e1_v  = 1'b1;
            e1    = unknown_rec(r_pend[0], 3'd1, addr_start);
            n_cnt = 3'd0;
            if (!opens(b)) begin
                e2_v = 1'b1;
            end else begin
                n_pend[0] = b;
                n_cnt     = 3'd1;
                n_start   = r_off;
            end
        end else if ({1'b0, r_cnt} + 4'd1 >= {1'b0, need}) begin
            e1_v  = 1'b1;
            e1    = decode_rec(bb[0], bb[1], bb[2], bb[3], bb[4], need, addr_start);
            n_cnt = 3'd0;
        end else begin
            n_pend[r_cnt[1:0]] = b;
            n_cnt              = r_cnt + 3'd1;
        end

        if (i_in.end_of_stream && n_cnt != 3'd0) begin
            e3_v  = 1'b1;
            e3    = unknown_rec(n_pend[0], n_cnt, i_load_address + n_start);
            n_cnt = 3'd0;
        end
    end

    always_comb begin
        o_push.v0 = accept && (e1_v || e3_v);
        o_push.v1 = accept && e1_v && (e2_v || e3_v);
        o_push.r0 = e1_v ? e1 : e3;
        o_push.r1 = e2_v ? e2 : e3;
        o_push.r0.is_last = i_in.end_of_stream && !(e1_v && (e2_v || e3_v));
        o_push.r1.is_last = i_in.end_of_stream;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= 3'd0;
            r_off   <= 16'd0;
            r_start <= 16'd0;
        end else if (accept) begin
            r_cnt   <= n_cnt;
            r_off   <= n_off;
            r_start <= n_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend <= n_pend;
        end
    end

endmodule

`default_nettype wire

// File: sv/x86d_queue.sv
`default_nettype none

module x86d_queue import x86d_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_push     i_push,
    output logic      o_space_ok,
    input  wire logic i_pop,
    output logic      o_nonempty,
    output t_rec      o_head
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_rec          r_mem [DEPTH];
    logic [PW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [PW-1:0] wptr1;
    logic [CW-1:0] r_count, n_count;

    function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign wptr1      = inc(r_wptr);
    assign o_space_ok = r_count <= CW'(DEPTH - 2);
    assign o_nonempty = r_count != '0;
    assign o_head     = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push.v0 && i_push.v1) begin
            n_wptr  = inc(wptr1);
            n_count = n_count + CW'(2);
        end else if (i_push.v0) begin
            n_wptr  = wptr1;
            n_count = n_count + CW'(1);
        end
        if (i_pop) begin
            n_rptr  = inc(r_rptr);
            n_count = n_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wptr] <= i_push.r0;
        end
        if (i_push.v1) begin
            r_mem[wptr1] <= i_push.r1;
        end
    end

endmodule

`default_nettype wire

// File: sv/x86d_back.sv
`default_nettype none

module x86d_back import x86d_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_nonempty,
    input  t_rec      i_head,
    output logic      o_pop,
    x86d_out_if.source o_out
);

    logic r_valid, n_valid;
    t_rec r_rec;

    // refill the output register from a nonempty queue whenever it is empty or being taken
    assign o_pop = i_nonempty && (!r_valid || o_out.ready);

    always_comb begin
        n_valid = r_valid;
        if (o_pop)            n_valid = 1'b1;
        else if (o_out.ready) n_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec <= i_head;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.form          = r_rec.form;
    assign o_out.dest_reg      = r_rec.dest_reg;
    assign o_out.src_reg       = r_rec.src_reg;
    assign o_out.word_value    = r_rec.word_value;
    assign o_out.byte_value    = r_rec.byte_value;
    assign o_out.length        = r_rec.length;
    assign o_out.instr_address = r_rec.instr_address;
    assign o_out.is_last       = r_rec.is_last;

endmodule

`default_nettype wire

// File: sv/x86_subset_instruction_decoder.sv
// Path: a record completed by a code byte is written into the record queue, then moves
// into the output register once that register is empty or being taken.
// Throughput: one code byte per cycle; a byte may yield two records, which leave one
// per cycle while taken; input stalls while the queue has fewer than two free slots.
// Reset (synchronous, active low): pending bytes dropped, stream offset zero,
// record queue and output emptied, load_address back to 0x100.
`default_nettype none

module x86_subset_instruction_decoder import x86d_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    x86d_in_if.sink          i_in,
    x86d_out_if.source       o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [0:0] REG_LOAD_ADDRESS = 1'b0;

    logic [15:0] r_load_address;
    logic        space_ok;
    logic        nonempty;
    logic        pop;
    t_push       push;
    t_rec        head;

    assign pready = 1'b1;
    assign prdata = (paddr[2:2] == REG_LOAD_ADDRESS) ? {16'd0, r_load_address} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_address <= LOAD_ADDRESS_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2:2] == REG_LOAD_ADDRESS) begin
            r_load_address <= pwdata[15:0];
        end
    end

    x86d_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (i_in),
        .i_load_address (r_load_address),
        .i_space_ok     (space_ok),
        .o_push         (push)
    );

    x86d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_space_ok (space_ok),
        .i_pop      (pop),
        .o_nonempty (nonempty),
        .o_head     (head)
    );

    x86d_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (nonempty),
        .i_head     (head),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire
